### src/rounded_rect_region_coverage_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rounded rectangle coverage block
// Concurrent checks compiled in simulation and left empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ROUNDED_RECT_REGION_COVERAGE_MACROS_SVH
`define ROUNDED_RECT_REGION_COVERAGE_MACROS_SVH
`ifndef SYNTHESIS
`define RRC_ASSERT_IMP(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("rrc: implication check failed");
`define RRC_ASSERT_NXT(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("rrc: next-cycle check failed");
`else
`define RRC_ASSERT_IMP(label, ck, rn, pre, post)
`define RRC_ASSERT_NXT(label, ck, rn, pre, post)
`endif
`endif

### src/rrc_pkg.sv
// ---------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants of the rounded rectangle coverage pipeline.
// ---------------------------------------------------------------------------
package rrc_pkg;

  localparam int DIM_W = 31;
  localparam int ROOT_W = 32;
  localparam int QUO_W = 16;
  localparam logic [16:0] COV_ONE = 17'd65536;

  localparam logic [2:0] REG_HALF_WIDTH = 3'd0;
  localparam logic [2:0] REG_HALF_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CORNER_RADIUS = 3'd2;
  localparam logic [2:0] REG_TRANSITION_WIDTH = 3'd3;
  localparam logic [2:0] REG_ROT_COS = 3'd4;
  localparam logic [2:0] REG_ROT_SIN = 3'd5;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_RAMP,
    MODE_CORNER
  } cov_mode_t;

  typedef struct packed {
    cov_mode_t        mode;
    logic [DIM_W-1:0] e;
  } side_t;

endpackage

### src/rounded_rect_region_coverage.sv
// ---------------------------------------------------------------------------
// rounded_rect_region_coverage
// Coverage of a rotated, centered rounded rectangle with linear falloff.
// ---------------------------------------------------------------------------
// Takes one point per clock while the output is not stalled and returns
// one item of coverage per point, in order. Six front stages do rotation,
// zone classification, squaring, the sum and the radius compare; then come
// the 32 one-bit stages of the corner square root and the 16 one-bit
// stages of the ramp divider. A stall at the output freezes the whole
// pipeline; in_ready is low only while an item waits at the output.
// Registers sit at byte addresses 4*i and should be written while no item
// is in flight.
// ---------------------------------------------------------------------------
`include "rounded_rect_region_coverage_macros.svh"

module rounded_rect_region_coverage import rrc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        out_coverage,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // config
  logic [DIM_W-1:0]   half_width_r, half_height_r, corner_radius_r, transition_width_r;
  logic signed [15:0] rot_cos_r, rot_sin_r;
  logic [61:0]        r2_r;
  logic [63:0]        rt2_r;
  logic [31:0]        rt;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r       <= '0;
      half_height_r      <= '0;
      corner_radius_r    <= '0;
      transition_width_r <= '0;
      rot_cos_r          <= 16'sd16384;
      rot_sin_r          <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HALF_WIDTH:       half_width_r       <= pwdata[DIM_W-1:0];
        REG_HALF_HEIGHT:      half_height_r      <= pwdata[DIM_W-1:0];
        REG_CORNER_RADIUS:    corner_radius_r    <= pwdata[DIM_W-1:0];
        REG_TRANSITION_WIDTH: transition_width_r <= pwdata[DIM_W-1:0];
        REG_ROT_COS:          rot_cos_r          <= pwdata[15:0];
        REG_ROT_SIN:          rot_sin_r          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HALF_WIDTH:       prdata = {1'b0, half_width_r};
      REG_HALF_HEIGHT:      prdata = {1'b0, half_height_r};
      REG_CORNER_RADIUS:    prdata = {1'b0, corner_radius_r};
      REG_TRANSITION_WIDTH: prdata = {1'b0, transition_width_r};
      REG_ROT_COS:          prdata = {{16{rot_cos_r[15]}}, rot_cos_r};
      REG_ROT_SIN:          prdata = {{16{rot_sin_r[15]}}, rot_sin_r};
      default:              prdata = '0;
    endcase
  end

  assign rt = {1'b0, corner_radius_r} + {1'b0, transition_width_r};

  always_ff @(posedge clk) begin
    r2_r  <= corner_radius_r * corner_radius_r;
    rt2_r <= rt * rt;
  end

  // pipeline control
  logic adv;
  logic out_valid_r;
  logic [16:0] out_coverage_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_coverage = out_coverage_r;

  // stage 1: products
  logic               p1_vld_r;
  logic signed [47:0] p1_cx_r, p1_sy_r, p1_sx_r, p1_cy_r;

  // stage 2: rotated point
  logic               p2_vld_r;
  logic signed [34:0] p2_u_r, p2_v_r;
  logic signed [48:0] du, dv;

  assign du = $signed({p1_cx_r[47], p1_cx_r}) - $signed({p1_sy_r[47], p1_sy_r});
  assign dv = $signed({p1_sx_r[47], p1_sx_r}) + $signed({p1_cy_r[47], p1_cy_r});

  // stage 3: zone classification
  logic               p3_vld_r;
  side_t              p3_side_r;
  logic [31:0]        p3_ax_r, p3_ay_r;
  logic signed [36:0] u37, v37, a37, b37, na37, nb37, hx37, hy37, t37;
  logic signed [36:0] cx37, cy37, dx37, dy37, e37;
  logic [36:0]        adx, ady;
  logic               c_ra, c_la, c_tb, c_bb, is_corner, is_center;
  side_t              cls_side;

  assign u37  = 37'(p2_u_r);
  assign v37  = 37'(p2_v_r);
  assign hx37 = $signed({6'd0, half_width_r});
  assign hy37 = $signed({6'd0, half_height_r});
  assign t37  = $signed({6'd0, transition_width_r});
  assign a37  = hx37 - $signed({6'd0, corner_radius_r});
  assign b37  = hy37 - $signed({6'd0, corner_radius_r});
  assign na37 = -a37;
  assign nb37 = -b37;
  assign c_ra = u37 > a37;
  assign c_la = u37 < na37;
  assign c_tb = v37 > b37;
  assign c_bb = v37 < nb37;

  always_comb begin
    is_corner = 1'b0;
    is_center = 1'b0;
    cx37 = a37;
    cy37 = b37;
    e37  = '0;
    if (c_ra && c_tb) begin
      is_corner = 1'b1;
    end else if (c_ra && c_bb) begin
      is_corner = 1'b1;
      cy37 = nb37;
    end else if (c_ra) begin
      e37 = u37 - hx37;
    end else if (c_la && c_tb) begin
      is_corner = 1'b1;
      cx37 = na37;
    end else if (c_la && c_bb) begin
      is_corner = 1'b1;
      cx37 = na37;
      cy37 = nb37;
    end else if (c_la) begin
      e37 = -hx37 - u37;
    end else if (c_tb) begin
      e37 = v37 - hy37;
    end else if (c_bb) begin
      e37 = -hy37 - v37;
    end else begin
      is_center = 1'b1;
    end
  end

  assign dx37 = u37 - cx37;
  assign dy37 = v37 - cy37;
  assign adx  = dx37[36] ? 37'(-dx37) : 37'(dx37);
  assign ady  = dy37[36] ? 37'(-dy37) : 37'(dy37);

  always_comb begin
    cls_side.e    = e37[DIM_W-1:0];
    cls_side.mode = MODE_ZERO;
    if (is_center) begin
      cls_side.mode = MODE_FULL;
    end else if (is_corner) begin
      if (adx[36:32] == '0 && ady[36:32] == '0) begin
        cls_side.mode = MODE_CORNER;
      end
    end else if (e37 < 0) begin
      cls_side.mode = MODE_FULL;
    end else if (e37 < t37) begin
      cls_side.mode = MODE_RAMP;
    end
  end

  // stage 4: squares, stage 5: sum, stage 6: radius compare
  logic        p4_vld_r, p5_vld_r, p6_vld_r;
  side_t       p4_side_r, p5_side_r, p6_side_r;
  logic [63:0] p4_sx_r, p4_sy_r, p6_d2_r;
  logic [64:0] p5_d2_r;
  side_t       cmp_side;

  always_comb begin
    cmp_side = p5_side_r;
    if (p5_side_r.mode == MODE_CORNER) begin
      if (p5_d2_r[64] || p5_d2_r[63:0] >= rt2_r) begin
        cmp_side.mode = MODE_ZERO;
      end else if (p5_d2_r[63:0] < {2'b00, r2_r}) begin
        cmp_side.mode = MODE_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
      p6_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_valid;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
      p6_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_cx_r   <= in_point_x * rot_cos_r;
      p1_sy_r   <= in_point_y * rot_sin_r;
      p1_sx_r   <= in_point_x * rot_sin_r;
      p1_cy_r   <= in_point_y * rot_cos_r;
      p2_u_r    <= du[48:14];
      p2_v_r    <= dv[48:14];
      p3_side_r <= cls_side;
      p3_ax_r   <= adx[31:0];
      p3_ay_r   <= ady[31:0];
      p4_side_r <= p3_side_r;
      p4_sx_r   <= p3_ax_r * p3_ax_r;
      p4_sy_r   <= p3_ay_r * p3_ay_r;
      p5_side_r <= p4_side_r;
      p5_d2_r   <= {1'b0, p4_sx_r} + {1'b0, p4_sy_r};
      p6_side_r <= cmp_side;
      p6_d2_r   <= p5_d2_r[63:0];
    end
  end

  // corner distance
  logic              sq_vld;
  side_t             sq_side;
  logic [ROOT_W-1:0] sq_root;

  rrc_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (p6_vld_r),
    .side_in  (p6_side_r),
    .rad_in   (p6_d2_r),
    .out_vld  (sq_vld),
    .side_out (sq_side),
    .root_out (sq_root)
  );

  // stage 7: corner excess
  logic  p7_vld_r;
  side_t p7_side_r;
  side_t ex_side;

  always_comb begin
    ex_side = sq_side;
    if (sq_side.mode == MODE_CORNER) begin
      ex_side.mode = MODE_RAMP;
      ex_side.e    = DIM_W'(sq_root - {1'b0, corner_radius_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_vld_r <= 1'b0;
    end else if (adv) begin
      p7_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p7_side_r <= ex_side;
    end
  end

  // ramp
  logic             dv_vld;
  side_t            dv_side;
  logic [QUO_W-1:0] dv_quo;
  logic             dv_rem_nz;
  logic [16:0]      cov;

  rrc_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (p7_vld_r),
    .side_in  (p7_side_r),
    .den      (transition_width_r),
    .out_vld  (dv_vld),
    .side_out (dv_side),
    .quo_out  (dv_quo),
    .rem_nz   (dv_rem_nz)
  );

  always_comb begin
    case (dv_side.mode)
      MODE_FULL: cov = COV_ONE;
      MODE_RAMP: cov = COV_ONE - {1'b0, dv_quo} - {16'd0, dv_rem_nz};
      default:   cov = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_coverage_r <= cov;
    end
  end

  `RRC_ASSERT_IMP(a_cov_range, clk, rst_n, out_valid_r, out_coverage_r <= COV_ONE)
  `RRC_ASSERT_IMP(a_root_ge_r, clk, rst_n, sq_vld && sq_side.mode == MODE_CORNER, sq_root >= {1'b0, corner_radius_r})
  `RRC_ASSERT_IMP(a_ramp_band, clk, rst_n, p7_vld_r && p7_side_r.mode == MODE_RAMP, p7_side_r.e < transition_width_r)
  `RRC_ASSERT_NXT(a_stall_hold, clk, rst_n, !adv, $stable(p7_side_r) && $stable(p7_vld_r))

endmodule

### src/rrc_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// rrc_sqrt_pipe
// Integer square root of a 64 bit value, one root bit per register stage.
// ---------------------------------------------------------------------------
module rrc_sqrt_pipe import rrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  side_t             side_in,
  input  logic [63:0]       rad_in,
  output logic              out_vld,
  output side_t             side_out,
  output logic [ROOT_W-1:0] root_out
);

  localparam int STEPS = ROOT_W;

  logic              vld_r  [0:STEPS-1];
  side_t             side_r [0:STEPS-1];
  logic [63:0]       rem_r  [0:STEPS-1];
  logic [ROOT_W-1:0] root_r [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    localparam int B = STEPS - 1 - i;
    logic              vld_i;
    side_t             side_i;
    logic [63:0]       rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [65:0]       trial;
    logic              take;

    if (i == 0) begin : g_src
      assign vld_i  = in_vld;
      assign side_i = side_in;
      assign rem_i  = rad_in;
      assign root_i = '0;
    end else begin : g_chain
      assign vld_i  = vld_r[i-1];
      assign side_i = side_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ({34'd0, root_i} << (B + 1)) + (66'd1 << (2 * B));
    assign take  = {2'b00, rem_i} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_i;
        rem_r[i]  <= take ? (rem_i - trial[63:0]) : rem_i;
        root_r[i] <= take ? (root_i | (ROOT_W'(1) << B)) : root_i;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign side_out = side_r[STEPS-1];
  assign root_out = root_r[STEPS-1];

endmodule

### src/rrc_div_pipe.sv
// ---------------------------------------------------------------------------
// rrc_div_pipe
// Restoring divider for (e * 2^16) / t with e < t, one quotient bit a stage.
// ---------------------------------------------------------------------------
module rrc_div_pipe import rrc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  side_t            side_in,
  input  logic [DIM_W-1:0] den,
  output logic             out_vld,
  output side_t            side_out,
  output logic [QUO_W-1:0] quo_out,
  output logic             rem_nz
);

  localparam int STEPS = QUO_W;

  logic             vld_r  [0:STEPS-1];
  side_t            side_r [0:STEPS-1];
  logic [DIM_W-1:0] rem_r  [0:STEPS-1];
  logic [QUO_W-1:0] quo_r  [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    logic             vld_i;
    side_t            side_i;
    logic [DIM_W-1:0] rem_i;
    logic [QUO_W-1:0] quo_i;
    logic [DIM_W:0]   rem2;
    logic             take;

    if (i == 0) begin : g_src
      assign vld_i  = in_vld;
      assign side_i = side_in;
      assign rem_i  = side_in.e;
      assign quo_i  = '0;
    end else begin : g_chain
      assign vld_i  = vld_r[i-1];
      assign side_i = side_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign quo_i  = quo_r[i-1];
    end

    assign rem2 = {rem_i, 1'b0};
    assign take = rem2 >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_i;
        rem_r[i]  <= take ? DIM_W'(rem2 - {1'b0, den}) : rem2[DIM_W-1:0];
        quo_r[i]  <= {quo_i[QUO_W-2:0], take};
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign side_out = side_r[STEPS-1];
  assign quo_out  = quo_r[STEPS-1];
  assign rem_nz   = rem_r[STEPS-1] != '0;

endmodule

### tb/rounded_rect_region_coverage_test.sv
// ---------------------------------------------------------------------------
// rounded_rect_region_coverage_test
// Self-checking bench for the rounded rectangle coverage pipeline.
// ---------------------------------------------------------------------------
// Programs the shape over an APB-style port across several phases, drives
// directed and random points with random valid/ready gaps, predicts each
// coverage item and compares results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module rounded_rect_region_coverage_test import rrc_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [16:0] out_coverage;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rounded_rect_region_coverage dut (.*);

  always #4 clk = ~clk;

  // shape settings mirrored in the bench
  logic [30:0] sh_hw, sh_hh, sh_rad, sh_tw;
  logic signed [15:0] sh_cos, sh_sin;

  point_t pending_points[$];
  logic [16:0] expected_cov[$];
  logic driver_hold = 1'b0;
  logic quiet = 1'b0;
  int errors = 0;
  int idle_count = 0;

  function automatic logic [16:0] ramp_cov(logic [63:0] e, logic [63:0] t);
    logic [63:0] q;
    if (t == 0 || e >= t) return 17'd0;
    q = (e * 64'd65536 + t - 1) / t;
    if (q >= 64'd65536) return 17'd0;
    return 17'(64'd65536 - q);
  endfunction

  function automatic logic [16:0] edge_cov(longint e, logic [63:0] t);
    if (e < 0) return COV_ONE;
    if (64'(e) < t) return ramp_cov(64'(e), t);
    return 17'd0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [16:0] corner_cov(longint u, longint v, longint cx,
                                             longint cy);
    longint dx, dy;
    logic [63:0] ax, ay, sx, sy, d2, r, t, rt;
    dx = u - cx;
    dy = v - cy;
    ax = dx < 0 ? 64'(-dx) : 64'(dx);
    ay = dy < 0 ? 64'(-dy) : 64'(dy);
    r = 64'(sh_rad);
    t = 64'(sh_tw);
    if (ax >= (64'd1 << 32) || ay >= (64'd1 << 32)) return 17'd0;
    sx = ax * ax;
    sy = ay * ay;
    if (sx > ~64'd0 - sy) return 17'd0;
    d2 = sx + sy;
    if (d2 < r * r) return COV_ONE;
    rt = r + t;
    if (d2 < rt * rt) return ramp_cov(int_sqrt(d2) - r, t);
    return 17'd0;
  endfunction

  function automatic logic [16:0] predict_coverage(point_t p);
    longint c, s, u, v, hx, hy, a, b;
    c = sh_cos;
    s = sh_sin;
    u = (c * longint'(p.x) - s * longint'(p.y)) >>> 14;
    v = (s * longint'(p.x) + c * longint'(p.y)) >>> 14;
    hx = longint'(sh_hw);
    hy = longint'(sh_hh);
    a = hx - longint'(sh_rad);
    b = hy - longint'(sh_rad);
    if (u > a && v > b) return corner_cov(u, v, a, b);
    if (u > a && v < -b) return corner_cov(u, v, a, -b);
    if (u > a) return edge_cov(u - hx, 64'(sh_tw));
    if (u < -a && v > b) return corner_cov(u, v, -a, b);
    if (u < -a && v < -b) return corner_cov(u, v, -a, -b);
    if (u < -a) return edge_cov(-hx - u, 64'(sh_tw));
    if (v > b) return edge_cov(v - hy, 64'(sh_tw));
    if (v < -b) return edge_cov(-hy - v, 64'(sh_tw));
    return COV_ONE;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_cov.push_back(predict_coverage({in_point_x, in_point_y}));
    end
    if (!in_valid || in_ready) begin
      if (pending_points.size() > 0 && !driver_hold &&
          (quiet || $urandom_range(99) >= 20)) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid <= 1'b1;
        in_point_x <= p.x;
        in_point_y <= p.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_cov.size() == 0) begin
        $error("unexpected item: coverage %0d", out_coverage);
        errors++;
      end else begin
        logic [16:0] want;
        want = expected_cov.pop_front();
        if (out_coverage !== want) begin
          $error("coverage mismatch: expected %0d actual %0d", want, out_coverage);
          errors++;
        end
      end
    end
    out_ready <= quiet || $urandom_range(99) >= 20;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n ||
        pending_points.size() == 0 && expected_cov.size() == 0)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HALF_WIDTH: sh_hw = val[30:0];
      REG_HALF_HEIGHT: sh_hh = val[30:0];
      REG_CORNER_RADIUS: sh_rad = val[30:0];
      REG_TRANSITION_WIDTH: sh_tw = val[30:0];
      REG_ROT_COS: sh_cos = val[15:0];
      REG_ROT_SIN: sh_sin = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || expected_cov.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(logic [31:0] hw, logic [31:0] hh, logic [31:0] rad,
                           logic [31:0] tw, logic [15:0] c, logic [15:0] s);
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_HALF_HEIGHT, hh);
    write_reg(REG_CORNER_RADIUS, rad);
    write_reg(REG_TRANSITION_WIDTH, tw);
    write_reg(REG_ROT_COS, {{16{c[15]}}, c});
    write_reg(REG_ROT_SIN, {{16{s[15]}}, s});
  endtask

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(4096);
      3: return $urandom;
      default: return $urandom_range(200000);
    endcase
  endfunction

  // random point, mostly near the shape boundary
  function automatic point_t rand_point();
    point_t p;
    longint span;
    span = longint'(sh_hw) + longint'(sh_rad) + 2 * longint'(sh_tw) + 64;
    if (span > 64'h3fff_ffff) span = 64'h3fff_ffff;
    if ($urandom_range(9) < 2) begin
      p.x = $urandom;
      p.y = $urandom;
    end else begin
      p.x = 32'(longint'($urandom_range(32'(2 * span))) - span);
      span = longint'(sh_hh) + longint'(sh_rad) + 2 * longint'(sh_tw) + 64;
      if (span > 64'h3fff_ffff) span = 64'h3fff_ffff;
      p.y = 32'(longint'($urandom_range(32'(2 * span))) - span);
    end
    return p;
  endfunction

  initial begin
    point_t p;
    sh_hw = 0; sh_hh = 0; sh_rad = 0; sh_tw = 0; sh_cos = 16384; sh_sin = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape: a point; extremes of the fields
    pending_points.push_back({32'sh8000_0000, 32'sh8000_0000});
    pending_points.push_back({32'sh7fff_ffff, 32'sh7fff_ffff});
    pending_points.push_back({32'sd0, 32'sd0});
    wait_drained();

    // rounded, with band: every zone, band edges, far corners
    set_shape(32'd1000, 32'd600, 32'd200, 32'd100, 16'sd16384, 16'sd0);
    pending_points.push_back({32'sd0, 32'sd0});
    pending_points.push_back({32'sd999, 32'sd0});
    pending_points.push_back({32'sd1000, 32'sd0});
    pending_points.push_back({32'sd1050, 32'sd0});
    pending_points.push_back({32'sd1100, 32'sd0});
    pending_points.push_back({-32'sd1050, 32'sd0});
    pending_points.push_back({32'sd0, 32'sd650});
    pending_points.push_back({32'sd0, -32'sd650});
    pending_points.push_back({32'sd900, 32'sd500});
    pending_points.push_back({32'sd950, 32'sd560});
    pending_points.push_back({32'sd980, -32'sd590});
    pending_points.push_back({-32'sd960, 32'sd570});
    pending_points.push_back({-32'sd940, -32'sd620});
    pending_points.push_back({32'sh7fff_ffff, 32'sh8000_0000});
    pending_points.push_back({32'sh8000_0000, 32'sh7fff_ffff});
    wait_drained();

    // radius larger than half size, sharp edge, odd trig patterns
    set_shape(32'd100, 32'd50, 32'd400, 32'd0, 16'sh8000, 16'sh7fff);
    pending_points.push_back({32'sd10, 32'sd10});
    pending_points.push_back({32'sd300, -32'sd200});
    pending_points.push_back({-32'sd5000, 32'sd7});
    wait_drained();

    // random phases; one stretch with no idling
    for (int ph = 0; ph < 19; ph++) begin
      if (ph == 3) set_shape(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h7fff_ffff, 16'sh8000, 16'sh8000);
      else if (ph == 4) set_shape(0, 0, 0, 0, -16'sd16384, 16'sd16384);
      else set_shape(rand_dim(), rand_dim(), rand_dim(), rand_dim(),
                     $urandom_range(3) == 0 ? 16'($urandom) :
                       16'($urandom_range(32768) - 16384),
                     $urandom_range(3) == 0 ? 16'($urandom) :
                       16'($urandom_range(32768) - 16384));
      quiet = (ph == 7);
      for (int k = 0; k < 100; k++) begin
        if (ph == 10 && k == 50) begin
          driver_hold = 1'b1;
          while (in_valid || expected_cov.size() > 0) @(posedge clk);
          driver_hold = 1'b0;
        end
        p = rand_point();
        pending_points.push_back(p);
        if (k % 20 == 19) @(posedge clk);
      end
      wait_drained();
      quiet = 1'b0;
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
